@@ hdl/adcseg_pkg.sv @@
package adcseg_pkg;

  localparam int unsigned AdcW     = 10;
  localparam int unsigned MvW      = 12;
  localparam int unsigned K1W      = 26;
  localparam int unsigned RadW     = 38;
  localparam int unsigned RootW    = 19;
  localparam int unsigned RemW     = 21;
  localparam int unsigned NumW     = 22;
  localparam int unsigned FracW    = 8;
  localparam int unsigned MagW     = 13;
  localparam int unsigned RecipW   = 17;
  localparam int unsigned RecipSh  = 18;
  localparam int unsigned TempW    = 12;
  localparam int unsigned ShownW   = 7;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned SegW     = 7;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  localparam logic [RadW-1:0]        RadK0   = 38'd192767259509;
  localparam logic [K1W-1:0]         RadK1   = 26'd37236364;
  localparam logic [RootW-1:0]       CelOff8 = 19'd392756;
  localparam logic signed [NumW-1:0] FahrOff = 22'sd40960;
  localparam logic [RecipW-1:0]      Recip5  = 17'd52429;
  localparam logic signed [TempW-1:0] DispMax = 12'sd99;
  localparam logic [ShownW-1:0]      ShownMax = 7'd99;

  localparam logic [SegW-1:0] SegZero  = 7'b1000000;
  localparam logic [SegW-1:0] SegOne   = 7'b1111001;
  localparam logic [SegW-1:0] SegTwo   = 7'b0100100;
  localparam logic [SegW-1:0] SegThree = 7'b0110000;
  localparam logic [SegW-1:0] SegFour  = 7'b0011001;
  localparam logic [SegW-1:0] SegFive  = 7'b0010010;
  localparam logic [SegW-1:0] SegSix   = 7'b0000010;
  localparam logic [SegW-1:0] SegSeven = 7'b1111000;
  localparam logic [SegW-1:0] SegEight = 7'b0000000;
  localparam logic [SegW-1:0] SegNine  = 7'b0010000;
  localparam logic [SegW-1:0] SegBlank = 7'b1111111;

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0: pat = SegZero;
      4'd1: pat = SegOne;
      4'd2: pat = SegTwo;
      4'd3: pat = SegThree;
      4'd4: pat = SegFour;
      4'd5: pat = SegFive;
      4'd6: pat = SegSix;
      4'd7: pat = SegSeven;
      4'd8: pat = SegEight;
      4'd9: pat = SegNine;
      default: pat = SegBlank;
    endcase
    return pat;
  endfunction

endpackage

@@ hdl/adcseg_isqrt.sv @@
module adcseg_isqrt
  import adcseg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RadW-1:0]  rad_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [RootW-1:0] root_o
);

  logic             vld_q  [RootW];
  logic [RadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RootW:0]   rdy;

  assign rdy[RootW] = out_ready_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic             v_in;
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  rsh;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rsh    = {rem_in, rad_in[RadW-1 -: 2]};
    assign trial  = {{(RemW-RootW){1'b0}}, root_in, 2'b01};
    assign ge     = (rsh >= trial);
    assign diff   = rsh - trial;
    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? diff[RemW-1:0] : rsh[RemW-1:0];
        root_q[k] <= {root_in[RootW-2:0], ge};
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[RootW-1];
  assign root_o      = root_q[RootW-1];

endmodule

@@ hdl/adc_temperature_to_seven_segment_unit.sv @@
// Converts a 10-bit converter code (4 mV per count) into whole degrees Fahrenheit
// through the sensor's square-root transfer curve and drives two active-low gfedcba
// digit patterns of the value clamped to 0..99; tuser flags a clamped reading. One
// beat is taken per clock unless the output stalls, and each result passes through
// one scaling stage, 19 square-root stages at one root bit each and four output
// stages; the square-root pipeline is the deepest part. Back-pressure on the output
// stalls the pipeline only as far as it is full.
module adc_temperature_to_seven_segment_unit
  import adcseg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // [9:0] adc_code
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [11:0] fahrenheit_whole,
                                             // [18:12] tens_segments,
                                             // [25:19] ones_segments
  output logic                m_axis_tuser   // [0] out_of_range
);

  logic                     rdy_a, rdy_c, rdy_d, rdy_e, rdy_f;
  logic                     sq_in_ready, sq_out_valid;
  logic [RootW-1:0]         sq_root;

  logic                     va_q;
  logic [RadW-1:0]          rad_q;
  logic [MvW-1:0]           mv_w;
  logic [RadW-1:0]          prod_w;

  logic                     vc_q;
  logic                     neg_q;
  logic [MagW-1:0]          mag_q;
  logic signed [NumW-1:0]   c8_w, num_w;
  logic [NumW-1:0]          abs_w;

  logic                     vd_q;
  logic signed [TempW-1:0]  fd_q, fd_d;
  logic [MagW+RecipW-1:0]   qprod_w;
  logic [TempW-2:0]         quot_w;

  logic                     ve_q;
  logic signed [TempW-1:0]  fe_q;
  logic [ShownW-1:0]        shown_q, shown_d;
  logic                     flag_e_q, flag_e_d;

  logic                     vf_q;
  logic signed [TempW-1:0]  ff_q;
  logic [SegW-1:0]          tens_seg_q, ones_seg_q;
  logic                     flag_f_q;
  logic [14:0]              tprod_w;
  logic [DigitW-1:0]        tens_w, ones_w;
  logic [ShownW-1:0]        tens10_w;

  assign rdy_f = !vf_q || m_axis_tready;
  assign rdy_e = !ve_q || rdy_f;
  assign rdy_d = !vd_q || rdy_e;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_a = !va_q || sq_in_ready;
  assign s_axis_tready = rdy_a;

  // scale to radicand
  assign mv_w   = {s_axis_tdata[AdcW-1:0], 2'b00};
  assign prod_w = RadW'(RadK1) * RadW'(mv_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid) begin
      rad_q <= RadK0 - prod_w;
    end
  end

  adcseg_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (va_q),
    .in_ready_o  (sq_in_ready),
    .rad_i       (rad_q),
    .out_valid_o (sq_out_valid),
    .out_ready_i (rdy_c),
    .root_o      (sq_root)
  );

  // Celsius to scaled Fahrenheit numerator, split into sign and magnitude
  assign c8_w  = NumW'($signed({1'b0, sq_root})) - NumW'($signed({1'b0, CelOff8}));
  assign num_w = (c8_w <<< 3) + c8_w + FahrOff;
  assign abs_w = num_w[NumW-1] ? NumW'(-num_w) : NumW'(num_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= sq_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && sq_out_valid) begin
      neg_q <= num_w[NumW-1];
      mag_q <= abs_w[MagW+FracW-1:FracW];
    end
  end

  // divide by five, truncate toward zero
  assign qprod_w = (MagW+RecipW)'(mag_q) * (MagW+RecipW)'(Recip5);
  assign quot_w  = qprod_w[RecipSh +: (TempW-1)];
  assign fd_d    = neg_q ? -$signed({1'b0, quot_w}) : $signed({1'b0, quot_w});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (rdy_d) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      fd_q <= fd_d;
    end
  end

  // clamp for display
  always_comb begin
    if (fd_q < 0) begin
      shown_d  = '0;
      flag_e_d = 1'b1;
    end else if (fd_q > DispMax) begin
      shown_d  = ShownMax;
      flag_e_d = 1'b1;
    end else begin
      shown_d  = fd_q[ShownW-1:0];
      flag_e_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (rdy_e) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && vd_q) begin
      fe_q     <= fd_q;
      shown_q  <= shown_d;
      flag_e_q <= flag_e_d;
    end
  end

  // split digits
  assign tprod_w  = 15'(shown_q) * 15'd205;
  assign tens_w   = tprod_w[14:11];
  assign tens10_w = ShownW'({tens_w, 3'b000}) + ShownW'({tens_w, 1'b0});
  assign ones_w   = DigitW'(shown_q - tens10_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (rdy_f) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f && ve_q) begin
      ff_q       <= fe_q;
      tens_seg_q <= seg_of(tens_w);
      ones_seg_q <= seg_of(ones_w);
      flag_f_q   <= flag_e_q;
    end
  end

  assign m_axis_tvalid = vf_q;
  assign m_axis_tdata  = {{(OutDataW-TempW-2*SegW){1'b0}}, ones_seg_q, tens_seg_q, ff_q};
  assign m_axis_tuser  = flag_f_q;

endmodule

@@ hdl/adcseg_chk.sv @@
module adcseg_chk
  import adcseg_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic signed [TempW-1:0] fahr;
  logic [SegW-1:0]         tens_seg, ones_seg;

  assign fahr     = $signed(m_axis_tdata[TempW-1:0]);
  assign tens_seg = m_axis_tdata[TempW +: SegW];
  assign ones_seg = m_axis_tdata[TempW+SegW +: SegW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ((fahr < 0) || (fahr > DispMax))))
    else $error("out_of_range disagrees with fahrenheit value");

  a_low_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fahr < 0) |-> (tens_seg == SegZero) && (ones_seg == SegZero))
    else $error("negative reading not shown as 00");

  a_high_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fahr > DispMax) |-> (tens_seg == SegNine) && (ones_seg == SegNine))
    else $error("reading above 99 not shown as 99");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:TempW+2*SegW] == '0)
      && (fahr >= -12'sd1317) && (fahr <= 12'sd357))
    else $error("fahrenheit out of span or padding not zero");

endmodule

bind adc_temperature_to_seven_segment_unit adcseg_chk u_adcseg_chk (.*);
